>>> rtl/usd_pkg.sv
// types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

   localparam logic [1:0] ST_VALID      = 2'd0;
   localparam logic [1:0] ST_BAD        = 2'd1;
   localparam logic [1:0] ST_INCOMPLETE = 2'd2;

   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] BYTE_MASK  = 8'hff;
   localparam int         CONT_BITS  = 6;
   localparam int         MAX_LENGTH = 7;

   typedef struct packed {
      logic [31:0] code_point;
      logic [1:0]  status;
      logic [2:0]  bytes_used;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic        hit;
      result_type  res;
      logic [2:0]  remaining;
      logic [31:0] accum;
      logic [2:0]  seq_length;
   } lead_type;

endpackage

`default_nettype wire

>>> rtl/utf8_stream_decoder_unit.sv
// top level of the utf-8 stream decoder with a three-entry result queue
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports
// req       in         req_valid, req_stall, req_in_byte
// rsp       out        rsp_valid, rsp_stall, rsp_code_point, rsp_status,
//                      rsp_bytes_used, rsp_last_of_run
//
// one request is taken per cycle while req_stall is low; its results enter
// the queue at that edge, and rsp_valid rises in the cycle after a request
// that gives a result is taken into an empty queue
// a request that gives two results fills two queue entries, so the request side stalls when results back up
// req_stall is high while two or more results wait in the queue
// synchronous reset clears the decode state and empties the queue

module utf8_stream_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_code_point,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_bytes_used,
   output logic             rsp_last_of_run
);

   logic [2:0]  remaining_ff, remaining_in;
   logic [31:0] accum_ff, accum_in;
   logic [2:0]  seq_ff, seq_in;

   usd_pkg::result_type queue_ff [3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   usd_pkg::result_type res0, res1;
   logic [1:0] n_res;
   logic       accept;
   logic       pop;
   logic [7:0] b;
   logic [31:0] cont_accum;
   logic [2:0]  min_len;
   usd_pkg::lead_type lead;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      ptr_inc = (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   function automatic logic [2:0] lead_ones(input logic [7:0] v);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && v[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      lead_ones = (n > 4'(usd_pkg::MAX_LENGTH)) ? 3'(usd_pkg::MAX_LENGTH) : n[2:0];
   endfunction

   function automatic usd_pkg::lead_type take_lead(input logic [7:0] v);
      usd_pkg::lead_type r;
      logic [2:0] ones;
      ones         = lead_ones(v);
      r.hit        = 1'b0;
      r.res        = '0;
      r.remaining  = 3'd0;
      r.accum      = 32'd0;
      r.seq_length = 3'd0;
      if (v != 8'd0) begin
         if (ones == 3'd0) begin
            r.hit            = 1'b1;
            r.res.code_point = {24'd0, v};
            r.res.status     = usd_pkg::ST_VALID;
            r.res.bytes_used = 3'd1;
         end else if (ones == 3'd1) begin
            r.hit            = 1'b1;
            r.res.status     = usd_pkg::ST_BAD;
            r.res.bytes_used = 3'd1;
         end else begin
            r.accum      = {24'd0, v & (usd_pkg::BYTE_MASK >> ones)};
            r.seq_length = ones;
            r.remaining  = ones - 3'd1;
         end
      end
      take_lead = r;
   endfunction

   assign req_stall = (count_ff > 2'd1);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign b         = req_in_byte;

   assign rsp_code_point  = queue_ff[rd_ptr_ff].code_point;
   assign rsp_status      = queue_ff[rd_ptr_ff].status;
   assign rsp_bytes_used  = queue_ff[rd_ptr_ff].bytes_used;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

   assign cont_accum = {accum_ff[31-usd_pkg::CONT_BITS:0], b[usd_pkg::CONT_BITS-1:0]};
   assign lead       = take_lead(b);

   // minimal sequence length from the highest set bit
   assign min_len = 3'd1 + 3'(|cont_accum[31:7]) + 3'(|cont_accum[31:11])
                  + 3'(|cont_accum[31:16]) + 3'(|cont_accum[31:21])
                  + 3'(|cont_accum[31:26]) + 3'(cont_accum[31]);

   always_comb begin
      remaining_in = remaining_ff;
      accum_in     = accum_ff;
      seq_in       = seq_ff;
      res0         = '0;
      res1         = '0;
      n_res        = 2'd0;
      if (accept) begin
         if (remaining_ff == 3'd0) begin
            res0         = lead.res;
            n_res        = {1'b0, lead.hit};
            remaining_in = lead.remaining;
            accum_in     = lead.accum;
            seq_in       = lead.seq_length;
         end else if ((b & usd_pkg::CONT_MASK) == usd_pkg::CONT_CODE) begin
            accum_in     = cont_accum;
            remaining_in = remaining_ff - 3'd1;
            if (remaining_ff == 3'd1) begin
               n_res           = 2'd1;
               res0.bytes_used = seq_ff;
               if (min_len == seq_ff) begin
                  res0.code_point = cont_accum;
                  res0.status     = usd_pkg::ST_VALID;
               end else begin
                  res0.status = usd_pkg::ST_BAD;
               end
               accum_in = 32'd0;
               seq_in   = 3'd0;
            end
         end else begin
            res0.status     = usd_pkg::ST_INCOMPLETE;
            res0.bytes_used = seq_ff - remaining_ff;
            res1            = lead.res;
            n_res           = lead.hit ? 2'd2 : 2'd1;
            remaining_in    = lead.remaining;
            accum_in        = lead.accum;
            seq_in          = lead.seq_length;
         end
      end
      res0.last_of_run = (n_res == 2'd1);
      res1.last_of_run = 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (n_res == 2'd1) begin
         wr_ptr_in = ptr_inc(wr_ptr_ff);
      end else if (n_res == 2'd2) begin
         wr_ptr_in = ptr_inc(ptr_inc(wr_ptr_ff));
      end
      if (pop) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
      end
      count_in = count_ff + n_res - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 3'd0;
         accum_ff     <= 32'd0;
         seq_ff       <= 3'd0;
         wr_ptr_ff    <= 2'd0;
         rd_ptr_ff    <= 2'd0;
         count_ff     <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
         accum_ff     <= accum_in;
         seq_ff       <= seq_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[ptr_inc(wr_ptr_ff)] <= res1;
      end
   end

endmodule

`default_nettype wire
